// ===== hw/rtl/tte_pkg.sv =====
// Shared types and constants for the text terminal escape parser.
`default_nettype none

package tte_pkg;

  // Escape parser modes
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_INIT   = 3'd1,
    MODE_FG     = 3'd2,
    MODE_BG     = 3'd3,
    MODE_POSX   = 3'd4,
    MODE_POSY   = 3'd5
  } mode_t;

  // Character codes
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_CLEAR = 8'h4a;  // 'J'
  localparam logic [7:0] CH_COLOR = 8'h6d;  // 'm'
  localparam logic [7:0] CH_HOME  = 8'h48;  // 'H'
  localparam logic [7:0] CH_SEP   = 8'h3b;  // ';'

  // Reset values
  localparam logic [4:0] RESET_ROW = 5'd19;
  localparam logic [3:0] RESET_FG  = 4'd2;
  localparam logic [3:0] RESET_BG  = 4'd0;

  // Saturation limits
  localparam logic [7:0] NUM_MAX    = 8'd255;
  localparam logic [3:0] COLOR_MAX  = 4'd15;
  localparam logic [1:0] DIGITS_MAX = 2'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/text_terminal_escape_parser.sv =====
// Text terminal: character decode, escape parser and cursor/cell write generation.
// A request transfer's result is registered and appears on the rsp side in the cycle after it.
// Throughput: one character per cycle; a single result register decouples the
// two sides, and a new character is taken whenever that register is empty or drains.
// Reset (rst, synchronous): parser to normal, cursor to column 0 / row 19,
// foreground green, background black, no result pending.
`default_nettype none

module text_terminal_escape_parser #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // character channel
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [7:0]  char_code,
  // result channel
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic             cell_write,
  output logic [10:0]      cell_index,
  output logic [15:0]      cell_word,
  output logic             clear_request,
  output logic [6:0]       cursor_col,
  output logic [4:0]       cursor_row
);

  localparam logic [6:0] COL_LAST = 7'(COLUMNS - 1);
  localparam logic [4:0] ROW_LAST = 5'(ROWS - 1);

  // Parser and cursor state
  tte_pkg::mode_t mode, mode_next;
  logic [6:0] col_pos, col_pos_next;
  logic [4:0] row_pos, row_pos_next;
  logic [3:0] fore_colour, fore_colour_next;
  logic [3:0] back_colour, back_colour_next;
  logic [1:0] digit_count, digit_count_next;
  logic [7:0] first_number, first_number_next;
  logic [7:0] second_number, second_number_next;

  // Result fields before the output register
  logic        wr_next;
  logic [10:0] idx_next;
  logic [15:0] word_next;
  logic        clr_next;

  logic accept;

  // Helpers
  function automatic logic [7:0] push_digit(input logic [7:0] acc, input logic [3:0] d);
    logic [11:0] acc_x;
    logic [11:0] sum;
    acc_x = 12'(acc);
    sum   = (acc_x << 3) + (acc_x << 1) + 12'(d);
    return (sum > 12'(tte_pkg::NUM_MAX)) ? tte_pkg::NUM_MAX : sum[7:0];
  endfunction

  function automatic logic [10:0] cell_addr(input logic [4:0] r, input logic [6:0] c);
    logic [11:0] a;
    a = 12'(r) * 12'(COLUMNS) + 12'(c);
    return a[10:0];
  endfunction

  // Next tab stop for every column, fixed at elaboration
  logic [7:0] tab_col [128];
  for (genvar i = 0; i < 128; i++) begin : g_tab
    assign tab_col[i] = 8'(i + TAB_STOP - (i % TAB_STOP));
  end

  // Character classes and shared arithmetic
  logic        is_digit;
  logic [3:0]  digit_val;
  logic [7:0]  first_pushed;
  logic [7:0]  second_pushed;
  logic [1:0]  count_inc;
  logic [4:0]  row_inc;
  logic [7:0]  col_inc;
  logic [7:0]  tab_target;
  logic [12:0] lead_add;
  logic [12:0] lead_sum;
  logic [7:0]  first_lead;
  logic [3:0]  colour_sat;
  logic [6:0]  pos_col;
  logic [4:0]  pos_row;

  always_comb begin
    is_digit      = (char_code >= tte_pkg::CH_ZERO) && (char_code <= tte_pkg::CH_NINE);
    digit_val     = 4'(char_code - tte_pkg::CH_ZERO);
    first_pushed  = push_digit(first_number, digit_val);
    second_pushed = push_digit(second_number, digit_val);
    count_inc     = (digit_count < tte_pkg::DIGITS_MAX) ? digit_count + 2'd1 : digit_count;
    row_inc       = (6'(row_pos) + 6'd1 >= 6'(ROWS)) ? 5'd0 : row_pos + 5'd1;
    col_inc       = 8'(col_pos) + 8'd1;
    tab_target    = tab_col[col_pos];
    // leading 3 or 4 scaled by the digits that followed it
    case (digit_count)
      2'd0:    lead_add = (mode == tte_pkg::MODE_FG) ? 13'd3    : 13'd4;
      2'd1:    lead_add = (mode == tte_pkg::MODE_FG) ? 13'd30   : 13'd40;
      2'd2:    lead_add = (mode == tte_pkg::MODE_FG) ? 13'd300  : 13'd400;
      default: lead_add = (mode == tte_pkg::MODE_FG) ? 13'd3000 : 13'd4000;
    endcase
    lead_sum   = 13'(first_number) + lead_add;
    first_lead = (lead_sum > 13'(tte_pkg::NUM_MAX)) ? tte_pkg::NUM_MAX : lead_sum[7:0];
    colour_sat = (first_number > 8'(tte_pkg::COLOR_MAX)) ? tte_pkg::COLOR_MAX
                                                         : first_number[3:0];
    pos_col    = (9'(first_number) >= 9'(COLUMNS)) ? COL_LAST : first_number[6:0];
    pos_row    = (9'(second_number) >= 9'(ROWS)) ? ROW_LAST : second_number[4:0];
  end

  // Next parser mode
  always_comb begin
    mode_next = tte_pkg::MODE_NORMAL;
    case (mode)
      tte_pkg::MODE_NORMAL: begin
        mode_next = (char_code == tte_pkg::CH_ESC) ? tte_pkg::MODE_INIT : tte_pkg::MODE_NORMAL;
      end
      tte_pkg::MODE_INIT: begin
        if (char_code == tte_pkg::CH_THREE) begin
          mode_next = tte_pkg::MODE_FG;
        end else if (char_code == tte_pkg::CH_FOUR) begin
          mode_next = tte_pkg::MODE_BG;
        end else if (is_digit) begin
          mode_next = tte_pkg::MODE_POSX;
        end
      end
      tte_pkg::MODE_FG, tte_pkg::MODE_BG: begin
        if (char_code == tte_pkg::CH_COLOR && digit_count != 2'd0) begin
          mode_next = tte_pkg::MODE_NORMAL;
        end else if (is_digit) begin
          mode_next = mode;
        end else if (char_code == tte_pkg::CH_SEP) begin
          mode_next = tte_pkg::MODE_POSY;
        end
      end
      tte_pkg::MODE_POSX: begin
        if (char_code == tte_pkg::CH_SEP && digit_count != 2'd0) begin
          mode_next = tte_pkg::MODE_POSY;
        end else if (is_digit) begin
          mode_next = tte_pkg::MODE_POSX;
        end
      end
      tte_pkg::MODE_POSY: begin
        if (is_digit) begin
          mode_next = tte_pkg::MODE_POSY;
        end
      end
      default: mode_next = tte_pkg::MODE_NORMAL;
    endcase
  end

  // Cursor, colours, accumulators and result fields
  always_comb begin
    col_pos_next       = col_pos;
    row_pos_next       = row_pos;
    fore_colour_next   = fore_colour;
    back_colour_next   = back_colour;
    // accumulators clear unless a sequence keeps going
    digit_count_next   = 2'd0;
    first_number_next  = 8'd0;
    second_number_next = 8'd0;
    wr_next            = 1'b0;
    idx_next           = 11'd0;
    word_next          = 16'd0;
    clr_next           = 1'b0;
    case (mode)
      tte_pkg::MODE_NORMAL: begin
        if (char_code == tte_pkg::CH_NL) begin
          col_pos_next = 7'd0;
          row_pos_next = row_inc;
        end else if (char_code == tte_pkg::CH_ESC) begin
          // accumulators already clear
        end else if (char_code == tte_pkg::CH_TAB) begin
          if (tab_target >= 8'(COLUMNS)) begin
            col_pos_next = 7'd0;
            row_pos_next = row_inc;
          end else begin
            col_pos_next = tab_target[6:0];
          end
        end else if (char_code == tte_pkg::CH_BS) begin
          // wrap to the previous line only from column 0
          if (col_pos == 7'd0) begin
            col_pos_next = COL_LAST;
            row_pos_next = (row_pos == 5'd0) ? ROW_LAST : row_pos - 5'd1;
          end else begin
            col_pos_next = col_pos - 7'd1;
          end
          wr_next  = 1'b1;
          idx_next = cell_addr(row_pos_next, col_pos_next);
        end else if (char_code == tte_pkg::CH_DEL) begin
          wr_next  = 1'b1;
          idx_next = cell_addr(row_pos, col_pos);
        end else begin
          wr_next   = 1'b1;
          idx_next  = cell_addr(row_pos, col_pos);
          word_next = {back_colour, fore_colour, char_code};
          if (col_inc >= 8'(COLUMNS)) begin
            col_pos_next = 7'd0;
            row_pos_next = row_inc;
          end else begin
            col_pos_next = col_inc[6:0];
          end
        end
      end
      tte_pkg::MODE_INIT: begin
        if (char_code == tte_pkg::CH_THREE || char_code == tte_pkg::CH_FOUR) begin
          // leading digit is held in the mode
        end else if (is_digit) begin
          first_number_next = 8'(digit_val);
          digit_count_next  = 2'd1;
        end else if (char_code == tte_pkg::CH_CLEAR) begin
          clr_next     = 1'b1;
          col_pos_next = 7'd0;
          row_pos_next = 5'd0;
        end
      end
      tte_pkg::MODE_FG, tte_pkg::MODE_BG: begin
        if (char_code == tte_pkg::CH_COLOR && digit_count != 2'd0) begin
          if (mode == tte_pkg::MODE_FG) begin
            fore_colour_next = colour_sat;
          end else begin
            back_colour_next = colour_sat;
          end
        end else if (is_digit) begin
          first_number_next = first_pushed;
          digit_count_next  = count_inc;
        end else if (char_code == tte_pkg::CH_SEP) begin
          first_number_next = first_lead;
        end
      end
      tte_pkg::MODE_POSX: begin
        if (char_code == tte_pkg::CH_SEP && digit_count != 2'd0) begin
          first_number_next = first_number;
        end else if (is_digit) begin
          first_number_next = first_pushed;
          digit_count_next  = count_inc;
        end
      end
      tte_pkg::MODE_POSY: begin
        if (char_code == tte_pkg::CH_HOME && digit_count != 2'd0) begin
          col_pos_next = pos_col;
          row_pos_next = pos_row;
        end else if (is_digit) begin
          first_number_next  = first_number;
          second_number_next = second_pushed;
          digit_count_next   = count_inc;
        end
      end
      default: begin
        // unused mode: back to normal, byte consumed
      end
    endcase
  end

  // Handshake: take a character when the result register is free or draining
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= tte_pkg::MODE_NORMAL;
      col_pos       <= 7'd0;
      row_pos       <= tte_pkg::RESET_ROW;
      fore_colour   <= tte_pkg::RESET_FG;
      back_colour   <= tte_pkg::RESET_BG;
      digit_count   <= 2'd0;
      first_number  <= 8'd0;
      second_number <= 8'd0;
    end else if (accept) begin
      mode          <= mode_next;
      col_pos       <= col_pos_next;
      row_pos       <= row_pos_next;
      fore_colour   <= fore_colour_next;
      back_colour   <= back_colour_next;
      digit_count   <= digit_count_next;
      first_number  <= first_number_next;
      second_number <= second_number_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cell_write    <= wr_next;
      cell_index    <= idx_next;
      cell_word     <= word_next;
      clear_request <= clr_next;
      cursor_col    <= col_pos_next;
      cursor_row    <= row_pos_next;
    end
  end

  // Checks
  a_clear_no_write: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && clear_request |-> !cell_write)
    else $error("clear and cell write in the same result");

  a_clear_homes: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && clear_request |-> cursor_col == 7'd0 && cursor_row == 5'd0)
    else $error("clear did not home the cursor");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> 8'(cursor_col) < 8'(COLUMNS))
    else $error("cursor column beyond the line");

  a_init_clean: assert property (@(posedge clk) disable iff (rst)
    mode == tte_pkg::MODE_INIT |->
      digit_count == 2'd0 && first_number == 8'd0 && second_number == 8'd0)
    else $error("escape start with stale accumulators");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid && cursor_col == $past(col_pos_next))
    else $error("accepted character gave no result");

endmodule

`default_nettype wire
